@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the top-level design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clk, suspended while rst_n is low
`define VSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge of clk, reset included
`define VSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/vsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_pkg
// types, codes and constants of the ventilator sensor monitor
// ----------------------------------------------------------------------------
package vsm_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int ACTION_W    = 3;
    localparam int MODE_W      = 2;
    localparam int CHAN_W      = 2;
    localparam int VALUE_W     = 21;
    localparam int ALARM_W     = 3;
    localparam int DISP_W      = 2;
    localparam int PRESS_W     = 8;
    localparam int TEMP_W      = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    // floor(n / 427) = (n * 157164) >> 26 for 0 <= n < 2^17
    localparam int              TEMP_DIV_SHIFT = 26;
    localparam logic [17:0]     TEMP_DIV_RECIP = 18'd157164;
    localparam logic [18:0]     TEMP_OFFSET    = 19'd80550;
    localparam logic [10:0]     FLOW_ZERO      = 11'd547;
    localparam logic [11:0]     FLOW_GAIN      = 12'd1839;
    localparam logic [12:0]     PRESS_BIAS     = 13'd30;
    localparam logic [PRESS_W-1:0] PRESS_OFFSET = 8'd4;

    localparam logic signed [PRESS_W-1:0] PEAK_CLEAR = -8'sd100;

    localparam logic signed [PRESS_W-1:0] RST_OVERPRESSURE = 8'sd40;
    localparam logic signed [PRESS_W-1:0] RST_CAL_PRESSURE = 8'sd5;
    localparam logic signed [PRESS_W-1:0] RST_NO_PRESSURE  = 8'sd5;
    localparam logic signed [PRESS_W-1:0] RST_LOW_PRESSURE = 8'sd10;
    localparam logic signed [TEMP_W-1:0]  RST_MACHINE_TEMP = 9'sd60;
    localparam logic signed [TEMP_W-1:0]  RST_MOTOR_TEMP   = 9'sd80;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE       = 3'd0,
        ACT_CLEAR_PEAK   = 3'd1,
        ACT_PUBLISH_PEAK = 3'd2,
        ACT_PLATEAU      = 3'd3,
        ACT_PEEP         = 3'd4
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OTHER = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_CAL   = 2'd2
    } mode_t;

    typedef enum logic [CHAN_W-1:0] {
        CH_PRESSURE     = 2'd0,
        CH_FLOW         = 2'd1,
        CH_MACHINE_TEMP = 2'd2,
        CH_MOTOR_TEMP   = 2'd3
    } chan_t;

    typedef enum logic [ALARM_W-1:0] {
        ALM_NONE         = 3'd0,
        ALM_OVERPRESSURE = 3'd1,
        ALM_PATIENT      = 3'd2,
        ALM_NO_PRESSURE  = 3'd3,
        ALM_LOW_PRESSURE = 3'd4,
        ALM_MACHINE_HOT  = 3'd5,
        ALM_MOTOR_HOT    = 3'd6
    } alarm_t;

    typedef enum logic [DISP_W-1:0] {
        DISP_NONE    = 2'd0,
        DISP_PEAK    = 2'd1,
        DISP_PLATEAU = 2'd2,
        DISP_PEEP    = 2'd3
    } disp_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERPRESSURE = 3'd0,
        CFG_CAL_PRESSURE = 3'd1,
        CFG_NO_PRESSURE  = 3'd2,
        CFG_LOW_PRESSURE = 3'd3,
        CFG_MACHINE_TEMP = 3'd4,
        CFG_MOTOR_TEMP   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [PRESS_W-1:0] overpressure;
        logic signed [PRESS_W-1:0] cal_pressure;
        logic signed [PRESS_W-1:0] no_pressure;
        logic signed [PRESS_W-1:0] low_pressure;
        logic signed [TEMP_W-1:0]  machine_temp;
        logic signed [TEMP_W-1:0]  motor_temp;
    } limits_t;

    typedef struct packed {
        logic signed [PRESS_W-1:0] pressure;
        logic signed [VALUE_W-1:0] flow;
        logic signed [TEMP_W-1:0]  temp;
    } conv_t;

    typedef struct packed {
        chan_t                     channel_done;
        logic signed [VALUE_W-1:0] value;
        chan_t                     next_channel;
        alarm_t                    alarm;
        logic                      motor_stop;
        disp_t                     display;
    } result_t;

endpackage

@@ design/vsm_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_cfg_regs
// alarm limit registers, written through the plain configuration port
// ----------------------------------------------------------------------------
module vsm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [vsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vsm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output vsm_pkg::limits_t                 limits
);

    vsm_pkg::limits_t limits_reg;
    vsm_pkg::limits_t limits_next;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_we)
        begin
            case (vsm_pkg::cfg_reg_t'(cfg_index))
                vsm_pkg::CFG_OVERPRESSURE:
                    limits_next.overpressure = cfg_data[vsm_pkg::PRESS_W-1:0];
                vsm_pkg::CFG_CAL_PRESSURE:
                    limits_next.cal_pressure = cfg_data[vsm_pkg::PRESS_W-1:0];
                vsm_pkg::CFG_NO_PRESSURE:
                    limits_next.no_pressure = cfg_data[vsm_pkg::PRESS_W-1:0];
                vsm_pkg::CFG_LOW_PRESSURE:
                    limits_next.low_pressure = cfg_data[vsm_pkg::PRESS_W-1:0];
                vsm_pkg::CFG_MACHINE_TEMP:
                    limits_next.machine_temp = cfg_data[vsm_pkg::TEMP_W-1:0];
                vsm_pkg::CFG_MOTOR_TEMP:
                    limits_next.motor_temp = cfg_data[vsm_pkg::TEMP_W-1:0];
                default:
                    limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.overpressure <= vsm_pkg::RST_OVERPRESSURE;
            limits_reg.cal_pressure <= vsm_pkg::RST_CAL_PRESSURE;
            limits_reg.no_pressure  <= vsm_pkg::RST_NO_PRESSURE;
            limits_reg.low_pressure <= vsm_pkg::RST_LOW_PRESSURE;
            limits_reg.machine_temp <= vsm_pkg::RST_MACHINE_TEMP;
            limits_reg.motor_temp   <= vsm_pkg::RST_MOTOR_TEMP;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

@@ design/vsm_convert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_convert
// converts a raw 10-bit reading to pressure, flow and temperature
// ----------------------------------------------------------------------------
module vsm_convert (
    input  logic [vsm_pkg::SAMPLE_W-1:0] sample,
    output vsm_pkg::conv_t               conv
);

    logic [12:0]        press_biased;
    logic signed [10:0] flow_diff;
    logic signed [22:0] flow_prod;
    logic [17:0]        s_x150;
    logic signed [18:0] temp_num;
    logic signed [18:0] temp_abs;
    logic               temp_neg;
    logic [16:0]        temp_mag;
    logic [34:0]        temp_prod;
    logic [7:0]         temp_quot;

    // pressure: floor((7s - 290) / 64) + 1, kept on a non-negative operand
    assign press_biased = {sample, 3'b000} - {3'b000, sample} + vsm_pkg::PRESS_BIAS;
    assign conv.pressure = $signed({1'b0, press_biased[12:6]})
                         - $signed(vsm_pkg::PRESS_OFFSET);

    // flow: (s - 547) * 1839
    assign flow_diff = $signed({1'b0, sample}) - $signed(vsm_pkg::FLOW_ZERO);
    assign flow_prod = flow_diff * $signed(vsm_pkg::FLOW_GAIN);
    assign conv.flow = flow_prod[vsm_pkg::VALUE_W-1:0];

    // temperature: (80550 - 150s) / 427 toward zero, by reciprocal on the magnitude
    assign s_x150   = {1'b0, sample, 7'b0} + {4'b0, sample, 4'b0}
                    + {6'b0, sample, 2'b0} + {7'b0, sample, 1'b0};
    assign temp_num = $signed(vsm_pkg::TEMP_OFFSET) - $signed({1'b0, s_x150});
    assign temp_neg = temp_num[18];
    assign temp_abs = temp_neg ? -temp_num : temp_num;
    assign temp_mag = temp_abs[16:0];
    assign temp_prod = temp_mag * vsm_pkg::TEMP_DIV_RECIP;
    assign temp_quot = temp_prod[vsm_pkg::TEMP_DIV_SHIFT +: 8];
    assign conv.temp = temp_neg ? -$signed({1'b0, temp_quot}) : $signed({1'b0, temp_quot});

endmodule

@@ design/vsm_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_eval
// channel sequencing, pressure tracking and alarm decisions for one beat
// ----------------------------------------------------------------------------
module vsm_eval (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [vsm_pkg::ACTION_W-1:0]  action,
    input  logic [vsm_pkg::MODE_W-1:0]    machine_mode,
    input  vsm_pkg::conv_t                conv,
    input  vsm_pkg::limits_t              limits,
    output vsm_pkg::result_t              res
);

    vsm_pkg::chan_t                     chan_reg;
    vsm_pkg::chan_t                     chan_next;
    logic signed [vsm_pkg::PRESS_W-1:0] last_press_reg;
    logic signed [vsm_pkg::PRESS_W-1:0] last_press_next;
    logic signed [vsm_pkg::PRESS_W-1:0] peak_reg;
    logic signed [vsm_pkg::PRESS_W-1:0] peak_next;

    function automatic logic signed [vsm_pkg::VALUE_W-1:0] VALUE_W_EXT(
        input logic signed [vsm_pkg::PRESS_W-1:0] p
    );
        VALUE_W_EXT = {{(vsm_pkg::VALUE_W-vsm_pkg::PRESS_W){p[vsm_pkg::PRESS_W-1]}}, p};
    endfunction

    always_comb
    begin
        chan_next       = chan_reg;
        last_press_next = last_press_reg;
        peak_next       = peak_reg;

        res.channel_done = vsm_pkg::CH_PRESSURE;
        res.value        = '0;
        res.alarm        = vsm_pkg::ALM_NONE;
        res.motor_stop   = 1'b0;
        res.display      = vsm_pkg::DISP_NONE;

        case (vsm_pkg::action_t'(action))
            vsm_pkg::ACT_SAMPLE:
            begin
                res.channel_done = chan_reg;
                chan_next = vsm_pkg::chan_t'(chan_reg + 2'd1);
                case (chan_reg)
                    vsm_pkg::CH_PRESSURE:
                    begin
                        last_press_next = conv.pressure;
                        res.value = VALUE_W_EXT(conv.pressure);
                        if (machine_mode == vsm_pkg::MODE_RUN)
                        begin
                            if (conv.pressure > limits.overpressure)
                            begin
                                res.alarm      = vsm_pkg::ALM_OVERPRESSURE;
                                res.motor_stop = 1'b1;
                            end
                            if (conv.pressure > peak_reg)
                                peak_next = conv.pressure;
                        end
                        else if (machine_mode == vsm_pkg::MODE_CAL)
                        begin
                            if (conv.pressure > limits.cal_pressure)
                            begin
                                res.alarm      = vsm_pkg::ALM_PATIENT;
                                res.motor_stop = 1'b1;
                            end
                        end
                    end
                    vsm_pkg::CH_FLOW:
                        res.value = conv.flow;
                    vsm_pkg::CH_MACHINE_TEMP:
                    begin
                        res.value = {{(vsm_pkg::VALUE_W-vsm_pkg::TEMP_W){conv.temp[8]}},
                                     conv.temp};
                        if (conv.temp > limits.machine_temp)
                            res.alarm = vsm_pkg::ALM_MACHINE_HOT;
                    end
                    default:
                    begin
                        res.value = {{(vsm_pkg::VALUE_W-vsm_pkg::TEMP_W){conv.temp[8]}},
                                     conv.temp};
                        if (conv.temp > limits.motor_temp)
                            res.alarm = vsm_pkg::ALM_MOTOR_HOT;
                    end
                endcase
            end
            vsm_pkg::ACT_CLEAR_PEAK:
            begin
                peak_next = vsm_pkg::PEAK_CLEAR;
                res.value = VALUE_W_EXT(vsm_pkg::PEAK_CLEAR);
            end
            vsm_pkg::ACT_PUBLISH_PEAK:
            begin
                res.value   = VALUE_W_EXT(peak_reg);
                res.display = vsm_pkg::DISP_PEAK;
                // no-pressure check wins over low-pressure
                if (peak_reg < limits.no_pressure)
                    res.alarm = vsm_pkg::ALM_NO_PRESSURE;
                else if (peak_reg < limits.low_pressure)
                    res.alarm = vsm_pkg::ALM_LOW_PRESSURE;
            end
            vsm_pkg::ACT_PLATEAU:
            begin
                res.value   = VALUE_W_EXT(last_press_reg);
                res.display = vsm_pkg::DISP_PLATEAU;
            end
            vsm_pkg::ACT_PEEP:
            begin
                res.value   = VALUE_W_EXT(last_press_reg);
                res.display = vsm_pkg::DISP_PEEP;
            end
            default:
            begin
                res.value = '0;
            end
        endcase

        res.next_channel = chan_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg       <= vsm_pkg::CH_PRESSURE;
            last_press_reg <= '0;
            peak_reg       <= vsm_pkg::PEAK_CLEAR;
        end
        else if (step)
        begin
            chan_reg       <= chan_next;
            last_press_reg <= last_press_next;
            peak_reg       <= peak_next;
        end
    end

endmodule

@@ design/ventilator_sensor_monitor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ventilator_sensor_monitor_top
// round-robin sensor monitor: converts pressure, flow and temperature
// readings, tracks the cycle peak and raises alarms
//
//   port group | dir | payload
//   -----------+-----+---------------------------------------------------
//   s_axis     | in  | tuser: action; tdata: sample, machine_mode
//   m_axis     | out | tdata: channel_done, value, next_channel, alarm,
//              |     |        motor_stop_request, display_update
//   cfg        | in  | cfg_we, cfg_index, cfg_data (limit registers)
//
// one beat per cycle sustained while m_axis_tready is high; a beat goes
// via the input register and the result register around the datapath
// reset clears both valid flags, points at the pressure channel, sets the
// cycle peak to -100 and loads the default limits
// with m_axis_tready low the result holds, the input register takes one
// more beat, then s_axis_tready drops
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ventilator_sensor_monitor_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] sample, [11:10] machine_mode, [15:12] zero
    input  logic [vsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] action
    input  logic [vsm_pkg::ACTION_W-1:0]      s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] channel_done, [22:2] value, [24:23] next_channel, [27:25] alarm,
    // [28] motor_stop_request, [30:29] display_update, [31] zero
    output logic [vsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [vsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                              in_valid_reg;
    logic [vsm_pkg::ACTION_W-1:0]      in_action_reg;
    logic [vsm_pkg::SAMPLE_W-1:0]      in_sample_reg;
    logic [vsm_pkg::MODE_W-1:0]        in_mode_reg;
    logic                              out_valid_reg;
    vsm_pkg::result_t                  out_res_reg;

    logic                              in_beat;
    logic                              advance;
    vsm_pkg::limits_t                  limits;
    vsm_pkg::conv_t                    conv;
    vsm_pkg::result_t                  res;

    // the item in the input register moves on when the result slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    vsm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    vsm_convert u_conv (
        .sample (in_sample_reg),
        .conv   (conv)
    );

    vsm_eval u_eval (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .action       (in_action_reg),
        .machine_mode (in_mode_reg),
        .conv         (conv),
        .limits       (limits),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_action_reg <= s_axis_tuser;
            in_sample_reg <= s_axis_tdata[vsm_pkg::SAMPLE_W-1:0];
            in_mode_reg   <= s_axis_tdata[vsm_pkg::SAMPLE_W +: vsm_pkg::MODE_W];
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0,
                            out_res_reg.display,
                            out_res_reg.motor_stop,
                            out_res_reg.alarm,
                            out_res_reg.next_channel,
                            out_res_reg.value,
                            out_res_reg.channel_done};

    // a moved item always lands in the result register
    `VSM_ASSERT(a_advance_fills_out, advance |=> out_valid_reg, "result register not loaded")

    // a waiting item never sits behind an empty result register
    `VSM_ASSERT(a_no_bubble, (in_valid_reg && !out_valid_reg) |=> out_valid_reg, "pipeline bubble")

    // motor stop only comes with a pressure alarm
    `VSM_ASSERT(a_stop_has_alarm, (out_valid_reg && out_res_reg.motor_stop) |-> (out_res_reg.alarm == vsm_pkg::ALM_OVERPRESSURE || out_res_reg.alarm == vsm_pkg::ALM_PATIENT), "motor stop without alarm")

    // display updates belong to non-sample beats, which report channel zero
    `VSM_ASSERT(a_display_chan, (out_valid_reg && out_res_reg.display != vsm_pkg::DISP_NONE) |-> (out_res_reg.channel_done == vsm_pkg::CH_PRESSURE), "display with channel set")

endmodule

@@ sim/tb_ventilator_sensor_monitor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ventilator_sensor_monitor_top
// self-checking bench for the ventilator sensor monitor
//
// a short table of hand-picked beats (reset state, reading extremes, every
// action and every alarm code) is followed by phases of random breath
// sequences and noise, each under a fresh set of limits, extremes included.
// a model of the channel rotation, the conversions and the alarm rules
// predicts beats the table does not fix, and the bench compares field by
// field. the source sends in bursts, the sink stalls on its own pattern and
// holds off once for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_ventilator_sensor_monitor_top;

    import vsm_pkg::*;

    localparam int NUM_DIRECTED    = 25;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int SETTLE_CYCLES   = 4;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_AFTER      = 300;
    localparam int CYCLE_LIMIT     = 400000;

    // action, mode and config index codes the block has to ignore or treat as plain
    localparam logic [ACTION_W-1:0]  ACT_SPARE_5  = 3'd5;
    localparam logic [ACTION_W-1:0]  ACT_SPARE_7  = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [SAMPLE_W-1:0] sample;
        logic [MODE_W-1:0]   mode;
        bit                  typed;
        result_t             want;
    } stim_row_t;

    localparam result_t NO_CHECK = '0;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [ACTION_W-1:0]    s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    ventilator_sensor_monitor_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // monitor model state, reset values
    int                lim_overpressure = 40;
    int                lim_cal_pressure = 5;
    int                lim_no_pressure  = 5;
    int                lim_low_pressure = 10;
    int                lim_machine_temp = 60;
    int                lim_motor_temp   = 80;
    logic [CHAN_W-1:0] chan_idx         = '0;
    int                press_last       = 0;
    int                peak_cycle       = -100;
    int                peak_published   = 0;

    stim_row_t offered_rows [$];
    result_t   expected_results [$];
    stim_row_t plan [$];
    stim_row_t directed_rows [NUM_DIRECTED];
    int        error_count  = 0;
    int        results_seen = 0;
    int        cycle_count  = 0;

    function automatic void apply_limit_write(logic [CFG_IDX_W-1:0] idx,
                                              logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_OVERPRESSURE: lim_overpressure = $signed(d[PRESS_W-1:0]);
            CFG_CAL_PRESSURE: lim_cal_pressure = $signed(d[PRESS_W-1:0]);
            CFG_NO_PRESSURE:  lim_no_pressure  = $signed(d[PRESS_W-1:0]);
            CFG_LOW_PRESSURE: lim_low_pressure = $signed(d[PRESS_W-1:0]);
            CFG_MACHINE_TEMP: lim_machine_temp = $signed(d[TEMP_W-1:0]);
            CFG_MOTOR_TEMP:   lim_motor_temp   = $signed(d[TEMP_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic result_t sensor_step(logic [ACTION_W-1:0] act,
                                            logic [SAMPLE_W-1:0] raw,
                                            logic [MODE_W-1:0]   mode);
        result_t r;
        int      s;
        int      conv;
        r    = '0;
        s    = raw;
        conv = 0;
        case (act)
            ACT_SAMPLE:
            begin
                r.channel_done = chan_t'(chan_idx);
                case (chan_idx)
                    CH_PRESSURE:
                    begin
                        // floor((7s - 290) / 64) + 1
                        press_last = ((7 * s - 290) >>> 6) + 1;
                        conv       = press_last;
                        if (mode == MODE_RUN)
                        begin
                            if (press_last > lim_overpressure)
                            begin
                                r.alarm      = ALM_OVERPRESSURE;
                                r.motor_stop = 1'b1;
                            end
                            if (press_last > peak_cycle)
                                peak_cycle = press_last;
                        end
                        else if (mode == MODE_CAL && press_last > lim_cal_pressure)
                        begin
                            r.alarm      = ALM_PATIENT;
                            r.motor_stop = 1'b1;
                        end
                    end
                    CH_FLOW:
                        conv = (s - 547) * 1839;
                    CH_MACHINE_TEMP:
                    begin
                        conv = (80550 - 150 * s) / 427;
                        if (conv > lim_machine_temp)
                            r.alarm = ALM_MACHINE_HOT;
                    end
                    default:
                    begin
                        conv = (80550 - 150 * s) / 427;
                        if (conv > lim_motor_temp)
                            r.alarm = ALM_MOTOR_HOT;
                    end
                endcase
                chan_idx = chan_idx + 1'b1;
            end
            ACT_CLEAR_PEAK:
            begin
                peak_cycle = -100;
                conv       = peak_cycle;
            end
            ACT_PUBLISH_PEAK:
            begin
                peak_published = peak_cycle;
                conv           = peak_published;
                r.display      = DISP_PEAK;
                // no-pressure wins over low-pressure
                if (peak_published < lim_no_pressure)
                    r.alarm = ALM_NO_PRESSURE;
                else if (peak_published < lim_low_pressure)
                    r.alarm = ALM_LOW_PRESSURE;
            end
            ACT_PLATEAU:
            begin
                conv      = press_last;
                r.display = DISP_PLATEAU;
            end
            ACT_PEEP:
            begin
                conv      = press_last;
                r.display = DISP_PEEP;
            end
            default: ;
        endcase
        r.value        = conv[VALUE_W-1:0];
        r.next_channel = chan_t'(chan_idx);
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want_v,
                                        logic signed [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endfunction

    // input beats feed the model, output beats are checked in order
    always @(posedge clk)
    begin : scoreboard
        stim_row_t row;
        result_t   predicted;
        result_t   want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("output beat with nothing expected: %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("channel_done", want.channel_done, m_axis_tdata[1:0]);
                    check_field("value", want.value, $signed(m_axis_tdata[22:2]));
                    check_field("next_channel", want.next_channel, m_axis_tdata[24:23]);
                    check_field("alarm", want.alarm, m_axis_tdata[27:25]);
                    check_field("motor_stop_request", want.motor_stop, m_axis_tdata[28]);
                    check_field("display_update", want.display, m_axis_tdata[30:29]);
                end
            end
            if (cfg_we)
                apply_limit_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                row       = offered_rows.pop_front();
                predicted = sensor_step(s_axis_tuser, s_axis_tdata[SAMPLE_W-1:0],
                                        s_axis_tdata[SAMPLE_W+MODE_W-1:SAMPLE_W]);
                expected_results.push_back(row.typed ? row.want : predicted);
            end
        end
    end

    // sink pacing: runs of always-ready, mostly-ready, coin-flip and sparse ready
    initial
    begin : sink_pacing
        int style;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(8, 64))
            begin
                @(posedge clk);
                if (!long_hold_done && results_seen >= HOLD_AFTER)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                    long_hold_done = 1'b1;
                end
                case (style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic drive_beat(input stim_row_t row);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.action;
        s_axis_tdata  <= {4'b0000, row.mode, row.sample};
        offered_rows.push_back(row);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic hold_source(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic stream_plan();
        int idx;
        int burst;
        idx = 0;
        while (idx < plan.size())
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < plan.size())
            begin
                drive_beat(plan[idx]);
                idx++;
                burst--;
            end
            if ($urandom_range(0, 2) != 0)
                hold_source($urandom_range(1, 8));
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // wait until every beat has come back, then let the pipe go quiet
    task automatic settle();
        while (offered_rows.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_limits(input logic [CFG_DATA_W-1:0] lims [6]);
        for (int i = CFG_OVERPRESSURE; i <= CFG_MOTOR_TEMP; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= lims[i];
            @(posedge clk);
        end
        // unmapped indexes must not disturb anything
        cfg_index <= CFG_SPARE_LO;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_index <= CFG_SPARE_HI;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_limit(input int idx);
        int v;
        if ($urandom_range(0, 1) == 0)
            return CFG_DATA_W'($urandom);
        if (idx >= CFG_MACHINE_TEMP)
            v = $urandom_range(0, 380) - 180;
        else
            v = $urandom_range(0, 125) - 10;
        return v[CFG_DATA_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic stim_row_t make_row(input logic [ACTION_W-1:0] act,
                                           input logic [MODE_W-1:0]   mode);
        stim_row_t row;
        row.action = act;
        row.sample = pick_raw();
        row.mode   = mode;
        row.typed  = 1'b0;
        row.want   = NO_CHECK;
        return row;
    endfunction

    // mostly whole breaths (clear, samples, plateau, samples, peep,
    // publish), the rest loose noise over every code
    task automatic build_plan(input int n);
        logic [MODE_W-1:0] breath_mode;
        plan.delete();
        while (plan.size() < n)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                breath_mode = ($urandom_range(0, 4) == 0) ? MODE_CAL : MODE_RUN;
                plan.push_back(make_row(ACT_CLEAR_PEAK, breath_mode));
                repeat ($urandom_range(1, 9))
                    plan.push_back(make_row(ACT_SAMPLE, breath_mode));
                plan.push_back(make_row(ACT_PLATEAU, breath_mode));
                repeat ($urandom_range(1, 9))
                    plan.push_back(make_row(ACT_SAMPLE, breath_mode));
                plan.push_back(make_row(ACT_PEEP, breath_mode));
                plan.push_back(make_row(ACT_PUBLISH_PEAK, breath_mode));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    plan.push_back(make_row(ACTION_W'($urandom), MODE_W'($urandom)));
            end
        end
    endtask

    initial
    begin : run_sequence
        logic [CFG_DATA_W-1:0] lims [6];

        directed_rows = '{
            '{ACT_PUBLISH_PEAK, 10'd0, MODE_OTHER, 1'b1,
              '{CH_PRESSURE, -21'sd100, CH_PRESSURE, ALM_NO_PRESSURE, 1'b0, DISP_PEAK}},
            '{ACT_PLATEAU, 10'd0, MODE_OTHER, 1'b1,
              '{CH_PRESSURE, 21'sd0, CH_PRESSURE, ALM_NONE, 1'b0, DISP_PLATEAU}},
            '{ACT_PEEP, 10'd1023, MODE_RUN, 1'b1,
              '{CH_PRESSURE, 21'sd0, CH_PRESSURE, ALM_NONE, 1'b0, DISP_PEEP}},
            '{ACT_CLEAR_PEAK, 10'd0, MODE_RUN, 1'b1,
              '{CH_PRESSURE, -21'sd100, CH_PRESSURE, ALM_NONE, 1'b0, DISP_NONE}},
            '{ACT_SPARE_5, 10'd1023, MODE_SPARE, 1'b1,
              '{CH_PRESSURE, 21'sd0, CH_PRESSURE, ALM_NONE, 1'b0, DISP_NONE}},
            '{ACT_SPARE_7, 10'd1023, MODE_RUN, 1'b1,
              '{CH_PRESSURE, 21'sd0, CH_PRESSURE, ALM_NONE, 1'b0, DISP_NONE}},
            '{ACT_SAMPLE, 10'd1023, MODE_RUN, 1'b1,
              '{CH_PRESSURE, 21'sd108, CH_FLOW, ALM_OVERPRESSURE, 1'b1, DISP_NONE}},
            '{ACT_SAMPLE, 10'd0, MODE_RUN, 1'b1,
              '{CH_FLOW, -21'sd1005933, CH_MACHINE_TEMP, ALM_NONE, 1'b0, DISP_NONE}},
            '{ACT_SAMPLE, 10'd0, MODE_RUN, 1'b1,
              '{CH_MACHINE_TEMP, 21'sd188, CH_MOTOR_TEMP, ALM_MACHINE_HOT, 1'b0,
                DISP_NONE}},
            '{ACT_SAMPLE, 10'd1023, MODE_RUN, 1'b1,
              '{CH_MOTOR_TEMP, -21'sd170, CH_PRESSURE, ALM_NONE, 1'b0, DISP_NONE}},
            '{ACT_PUBLISH_PEAK, 10'd0, MODE_RUN, 1'b1,
              '{CH_PRESSURE, 21'sd108, CH_PRESSURE, ALM_NONE, 1'b0, DISP_PEAK}},
            '{ACT_CLEAR_PEAK, 10'd0, MODE_RUN, 1'b1,
              '{CH_PRESSURE, -21'sd100, CH_PRESSURE, ALM_NONE, 1'b0, DISP_NONE}},
            // peak of 7 lands between the no-pressure and low-pressure limits
            '{ACT_SAMPLE, 10'd97, MODE_RUN, 1'b0, NO_CHECK},
            '{ACT_PUBLISH_PEAK, 10'd0, MODE_RUN, 1'b1,
              '{CH_PRESSURE, 21'sd7, CH_FLOW, ALM_LOW_PRESSURE, 1'b0, DISP_PEAK}},
            '{ACT_SAMPLE, 10'd1023, MODE_OTHER, 1'b1,
              '{CH_FLOW, 21'sd875364, CH_MACHINE_TEMP, ALM_NONE, 1'b0, DISP_NONE}},
            '{ACT_SAMPLE, 10'd1023, MODE_OTHER, 1'b1,
              '{CH_MACHINE_TEMP, -21'sd170, CH_MOTOR_TEMP, ALM_NONE, 1'b0, DISP_NONE}},
            '{ACT_SAMPLE, 10'd0, MODE_OTHER, 1'b1,
              '{CH_MOTOR_TEMP, 21'sd188, CH_PRESSURE, ALM_MOTOR_HOT, 1'b0, DISP_NONE}},
            // calibration raises its own alarm and leaves the peak alone
            '{ACT_SAMPLE, 10'd1023, MODE_CAL, 1'b1,
              '{CH_PRESSURE, 21'sd108, CH_FLOW, ALM_PATIENT, 1'b1, DISP_NONE}},
            '{ACT_PLATEAU, 10'd0, MODE_CAL, 1'b1,
              '{CH_PRESSURE, 21'sd108, CH_FLOW, ALM_NONE, 1'b0, DISP_PLATEAU}},
            '{ACT_SAMPLE, 10'd547, MODE_OTHER, 1'b0, NO_CHECK},
            '{ACT_SAMPLE, 10'd537, MODE_OTHER, 1'b0, NO_CHECK},
            '{ACT_SAMPLE, 10'd536, MODE_OTHER, 1'b0, NO_CHECK},
            // mode three does no pressure checks
            '{ACT_SAMPLE, 10'd1023, MODE_SPARE, 1'b1,
              '{CH_PRESSURE, 21'sd108, CH_FLOW, ALM_NONE, 1'b0, DISP_NONE}},
            '{ACT_PEEP, 10'd0, MODE_SPARE, 1'b1,
              '{CH_PRESSURE, 21'sd108, CH_FLOW, ALM_NONE, 1'b0, DISP_PEEP}},
            '{ACT_PUBLISH_PEAK, 10'd0, MODE_RUN, 1'b0, NO_CHECK}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.delete();
        foreach (directed_rows[i])
            plan.push_back(directed_rows[i]);
        stream_plan();
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1: lims = '{9'h07F, 9'h07F, 9'h07F, 9'h07F, 9'h0FF, 9'h0FF};
                3: lims = '{9'h180, 9'h180, 9'h080, 9'h180, 9'h100, 9'h100};
                default:
                    foreach (lims[i])
                        lims[i] = random_limit(i);
            endcase
            program_limits(lims);
            build_plan(ITEMS_PER_PHASE);
            stream_plan();
            settle();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
